[sv/slsp_pkg.sv]
package slsp_pkg;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_CTRL = 2'd2;

	localparam logic [9:0] FAST_PERIOD   = 10'd16;
	localparam logic [9:0] SLOW_PERIOD   = 10'd512;
	localparam logic [9:0] TICK_CYCLES   = 10'd4;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	localparam int CTRL_START  = 7;
	localparam int CTRL_FAST   = 1;
	localparam int CTRL_INTCLK = 0;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] write_value;
		logic       partner_bit;
		logic       partner_connected;
	} slsp_in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [7:0] control_byte;
		logic       bit_sent;
		logic       bit_shifted;
		logic       serial_interrupt;
		logic       partner_notify;
	} slsp_out_t;

endpackage

[sv/slsp_core.sv]
module slsp_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              color_mode,
	input  slsp_pkg::slsp_in_t  item,
	output slsp_pkg::slsp_out_t result
);
	import slsp_pkg::*;

	logic [9:0] cycle_count_q, cycle_count_d;
	logic [9:0] bit_period_q, bit_period_d;
	logic [3:0] bits_done_q, bits_done_d;
	logic [7:0] data_reg_q, data_reg_d;
	logic [7:0] control_reg_q, control_reg_d;

	always_comb begin
		logic [9:0] sum;
		logic       incoming;
		sum           = cycle_count_q + TICK_CYCLES;
		incoming      = item.partner_connected ? item.partner_bit : 1'b1;
		cycle_count_d = cycle_count_q;
		bit_period_d  = bit_period_q;
		bits_done_d   = bits_done_q;
		data_reg_d    = data_reg_q;
		control_reg_d = control_reg_q;
		result        = '0;
		unique case (item.func)
			FUNC_DATA: begin
				data_reg_d = item.write_value;
			end
			FUNC_CTRL: begin
				control_reg_d = item.write_value;
				bit_period_d  = (color_mode && item.write_value[CTRL_FAST]) ?
					FAST_PERIOD : SLOW_PERIOD;
			end
			FUNC_TICK: begin
				cycle_count_d = sum;
				if (sum >= bit_period_q) begin
					cycle_count_d = sum - bit_period_q;
					if (control_reg_q[CTRL_START] && control_reg_q[CTRL_INTCLK]) begin
						if (bits_done_q < BITS_PER_BYTE) begin
							bits_done_d        = bits_done_q + 4'd1;
							result.bit_sent    = data_reg_q[7];
							data_reg_d         = {data_reg_q[6:0], incoming};
							result.bit_shifted = 1'b1;
						end else begin
							bits_done_d                = '0;
							control_reg_d[CTRL_START]  = 1'b0;
							result.serial_interrupt    = 1'b1;
							result.partner_notify      = item.partner_connected;
						end
					end
				end
			end
			default: begin
			end
		endcase
		result.data_byte    = data_reg_d;
		result.control_byte = control_reg_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count_q <= '0;
			bit_period_q  <= SLOW_PERIOD;
			bits_done_q   <= '0;
			data_reg_q    <= '0;
			control_reg_q <= '0;
		end else if (advance) begin
			cycle_count_q <= cycle_count_d;
			bit_period_q  <= bit_period_d;
			bits_done_q   <= bits_done_d;
			data_reg_q    <= data_reg_d;
			control_reg_q <= control_reg_d;
		end
	end

	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_done_q <= BITS_PER_BYTE)
		else $error("bit count past one byte");

	a_period_legal: assert property (@(posedge clk) disable iff (!arst_n)
		bit_period_q == FAST_PERIOD || bit_period_q == SLOW_PERIOD)
		else $error("illegal bit period");

	a_period_only_on_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && item.func == FUNC_CTRL) |=> $stable(bit_period_q))
		else $error("bit period changed without control write");

endmodule

[sv/serial_link_shift_port_top.sv]
// Accepted beats pass the input register, then the result register.
// Throughput: one beat per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Reset (arst_n low, asynchronous): data and control bytes, cycle and bit
// counters and color mode clear, bit period returns to 512, no beats held.
module serial_link_shift_port_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  slsp_pkg::slsp_in_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output slsp_pkg::slsp_out_t out_data
);
	import slsp_pkg::*;

	logic      color_mode_q;
	logic      valid_s1;
	slsp_in_t  item_s1;
	logic      advance;
	slsp_out_t result;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (cfg_we) begin
			color_mode_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_data;
		end
	end

	slsp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.color_mode (color_mode_q),
		.item       (item_s1),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || !out_stall) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

	a_notify_needs_irq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.partner_notify || out_data.serial_interrupt))
		else $error("partner notify without interrupt");

	a_sent_needs_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!out_data.bit_sent || out_data.bit_shifted))
		else $error("bit sent without shift");

	a_irq_excl_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.serial_interrupt && out_data.bit_shifted))
		else $error("interrupt and shift in one beat");

	a_advance_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("processed beat lost");

endmodule
